/* design/klcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klcp_pkg: shared types and constants
// Field widths, opcodes, register indexes, FSM states and the structs passed
// between the controller and the suffix walker.
// ----------------------------------------------------------------------------
package klcp_pkg;

    localparam int OP_W       = 2;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int CH_W       = 8;
    localparam int LIM_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // item opcodes (code 3 is unused and returns an all-zero result)
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPARE = 2'd1,
        OP_READ    = 2'd2
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH    = 4'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_CMP_A,
        ST_CMP_B,
        ST_FIN
    } t_state;

    // one position record
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] partner;
    } t_rec;

    // controller to walker
    typedef struct packed {
        logic             start;
        logic             load;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [CH_W-1:0]  ch;
    } t_walk_cmd;

    // walker to controller
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] match;
    } t_walk_sts;

endpackage
`default_nettype wire

/* design/klcp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klcp_if: valid/ready channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface klcp_item_if;
    logic                          valid;
    logic                          ready;
    logic [klcp_pkg::OP_W-1:0]     op;
    logic [klcp_pkg::POS_W-1:0]    first_position;
    logic [klcp_pkg::POS_W-1:0]    second_position;
    logic [klcp_pkg::CH_W-1:0]     character;

    modport source (output valid, op, first_position, second_position, character,
                    input ready);
    modport sink   (input valid, op, first_position, second_position, character,
                    output ready);
endinterface

interface klcp_result_if;
    logic                          valid;
    logic                          ready;
    logic [klcp_pkg::LEN_W-1:0]    match_length;
    logic [klcp_pkg::LEN_W-1:0]    best_length;
    logic [klcp_pkg::POS_W-1:0]    best_partner;

    modport source (output valid, match_length, best_length, best_partner,
                    input ready);
    modport sink   (input valid, match_length, best_length, best_partner,
                    output ready);
endinterface

interface klcp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [klcp_pkg::CFG_IDX_W-1:0]    index;
    logic [klcp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/klcp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klcp_ram: generic synchronous RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module klcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule
`default_nettype wire

/* design/klcp_walk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klcp_walk: text store and suffix walker
// Holds the text and walks two suffixes one character pair per cycle,
// issuing the next read while the current pair is compared.
// ----------------------------------------------------------------------------
module klcp_walk #(
    parameter int unsigned TEXT_DEPTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire klcp_pkg::t_walk_cmd           i_cmd,
    input  wire logic [klcp_pkg::LEN_W-1:0]    i_end,
    input  wire logic [klcp_pkg::LIM_W-1:0]    i_limit,
    output klcp_pkg::t_walk_sts                o_sts
);

    localparam int AW = $clog2(TEXT_DEPTH);

    logic                         r_active;
    logic                         r_rd_ok;
    logic [klcp_pkg::POS_W-1:0]   r_a;
    logic [klcp_pkg::POS_W-1:0]   r_b;
    logic [klcp_pkg::LEN_W-1:0]   r_match;
    logic [klcp_pkg::LIM_W-1:0]   r_err;

    logic [klcp_pkg::POS_W-1:0]   w_base_a;
    logic [klcp_pkg::POS_W-1:0]   w_base_b;
    logic [klcp_pkg::LEN_W-1:0]   w_idx;
    logic [klcp_pkg::LEN_W:0]     w_sum_a;
    logic [klcp_pkg::LEN_W:0]     w_sum_b;
    logic                         w_inb;
    logic                         w_mismatch;
    logic                         w_advance;
    logic [klcp_pkg::CH_W-1:0]    w_rd_a;
    logic [klcp_pkg::CH_W-1:0]    w_rd_b;

    // next pair to read: index 0 on start, else one past the current pair
    always_comb begin
        w_base_a   = i_cmd.start ? i_cmd.pos_a : r_a;
        w_base_b   = i_cmd.start ? i_cmd.pos_b : r_b;
        w_idx      = i_cmd.start ? '0 : r_match + 13'd1;
        w_sum_a    = 14'(w_base_a) + 14'(w_idx);
        w_sum_b    = 14'(w_base_b) + 14'(w_idx);
        w_inb      = (w_sum_a < 14'(i_end)) && (w_sum_b < 14'(i_end));
        w_mismatch = (w_rd_a != w_rd_b);
        // stop when out of text or one more mismatch would exceed the limit
        w_advance  = r_active && r_rd_ok && !(w_mismatch && (r_err == i_limit));
    end

    klcp_ram #(
        .WIDTH (klcp_pkg::CH_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text (
        .i_clk    (i_clk),
        .i_we     (i_cmd.load),
        .i_waddr  (AW'(i_cmd.pos_a)),
        .i_wdata  (i_cmd.ch),
        .i_raddr0 (AW'(w_sum_a)),
        .i_raddr1 (AW'(w_sum_b)),
        .o_rdata0 (w_rd_a),
        .o_rdata1 (w_rd_b)
    );

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
            r_match  <= '0;
            r_err    <= '0;
        end else if (i_cmd.start) begin
            r_active <= 1'b1;
            r_rd_ok  <= w_inb;
            r_a      <= i_cmd.pos_a;
            r_b      <= i_cmd.pos_b;
            r_match  <= '0;
            r_err    <= '0;
        end else if (w_advance) begin
            r_rd_ok  <= w_inb;
            r_match  <= r_match + 13'd1;
            r_err    <= r_err + {7'b0, w_mismatch};
        end else if (r_active) begin
            r_active <= 1'b0;
        end
    end

    assign o_sts.done  = r_active && !w_advance;
    assign o_sts.match = r_match;

endmodule
`default_nettype wire

/* design/k_mismatch_lcp_pair_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_mismatch_lcp_pair_update: k-mismatch common prefix with record update
// Keeps a text and a best-length/partner record per position. Loads write a
// character and clear its record, compares walk two suffixes and raise each
// record that the match length exceeds, reads return one record.
//
//  Channel    Dir  Handshake     Payload
//  i_cfg      in   valid/ready   index, data
//  i_item     in   valid/ready   op, first_position, second_position, character
//  o_result   out  valid/ready   match_length, best_length, best_partner
//
// The walk compares one character pair per cycle through the two read ports
// of the text RAM. After reset a clearing pass zeroes the record RAM; no item
// is accepted until it ends, configuration writes are always taken.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module k_mismatch_lcp_pair_update #(
    parameter int unsigned TEXT_DEPTH = 4096
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    klcp_cfg_if.sink       i_cfg,
    klcp_item_if.sink      i_item,
    klcp_result_if.source  o_result
);

    localparam int            AW      = $clog2(TEXT_DEPTH);
    localparam logic [20:0]   DEPTH_W = 21'(TEXT_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(TEXT_DEPTH - 1);

    klcp_pkg::t_state              r_state;
    klcp_pkg::t_state              n_state;
    logic [AW-1:0]                 r_clr;
    logic [klcp_pkg::LIM_W-1:0]    r_limit;
    logic [klcp_pkg::LEN_W-1:0]    r_text_length;

    logic [klcp_pkg::POS_W-1:0]    r_a;
    logic [klcp_pkg::POS_W-1:0]    r_b;
    logic                          r_a_ok;
    logic                          r_b_ok;
    logic                          r_upd_b;
    logic [klcp_pkg::LEN_W-1:0]    r_res_len;
    klcp_pkg::t_rec                r_res_rec;

    logic                          r_out_valid;
    logic [klcp_pkg::LEN_W-1:0]    r_out_len;
    klcp_pkg::t_rec                r_out_rec;

    logic                          w_accept;
    logic                          w_in_ok;
    logic [klcp_pkg::LEN_W-1:0]    w_end;
    logic                          w_out_load;
    logic                          w_upd_a;
    logic                          w_upd_b;

    logic                          w_rec_we;
    logic [AW-1:0]                 w_rec_waddr;
    klcp_pkg::t_rec                w_rec_wdata;
    logic [AW-1:0]                 w_rec_raddr0;
    klcp_pkg::t_rec                w_rec0;
    klcp_pkg::t_rec                w_rec1;

    klcp_pkg::t_walk_cmd           w_walk_cmd;
    klcp_pkg::t_walk_sts           w_walk_sts;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= '0;
            r_text_length <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                klcp_pkg::CFG_MISMATCH_LIMIT: r_limit <= i_cfg.data[klcp_pkg::LIM_W-1:0];
                klcp_pkg::CFG_TEXT_LENGTH:    r_text_length <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // effective text end and position range check
    assign w_end    = ({8'b0, r_text_length} > DEPTH_W) ? 13'(TEXT_DEPTH) : r_text_length;
    assign w_in_ok  = ({9'b0, i_item.first_position} < DEPTH_W);
    assign w_accept = i_item.valid && i_item.ready;
    assign w_upd_a  = r_a_ok && (r_res_len > w_rec0.len);
    assign w_upd_b  = r_b_ok && (r_res_len > w_rec1.len);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            klcp_pkg::ST_CLEAR: if (r_clr == LAST) n_state = klcp_pkg::ST_IDLE;
            klcp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.op)
                        klcp_pkg::OP_COMPARE: n_state = klcp_pkg::ST_WALK;
                        klcp_pkg::OP_READ:
                            n_state = w_in_ok ? klcp_pkg::ST_READ : klcp_pkg::ST_FIN;
                        default:              n_state = klcp_pkg::ST_FIN;
                    endcase
                end
            end
            klcp_pkg::ST_WALK:  if (w_walk_sts.done) n_state = klcp_pkg::ST_CMP_A;
            klcp_pkg::ST_READ:  n_state = klcp_pkg::ST_FIN;
            klcp_pkg::ST_CMP_A: n_state = klcp_pkg::ST_CMP_B;
            klcp_pkg::ST_CMP_B: n_state = klcp_pkg::ST_FIN;
            klcp_pkg::ST_FIN:   if (!r_out_valid || o_result.ready) n_state = klcp_pkg::ST_IDLE;
            default:            n_state = klcp_pkg::ST_IDLE;
        endcase
    end

    // state outputs: record RAM port, walker command, output load
    always_comb begin
        i_item.ready     = (r_state == klcp_pkg::ST_IDLE);
        w_rec_we         = 1'b0;
        w_rec_waddr      = AW'(r_a);
        w_rec_wdata      = '0;
        w_rec_raddr0     = AW'(r_a);
        w_out_load       = 1'b0;
        w_walk_cmd.start = 1'b0;
        w_walk_cmd.load  = 1'b0;
        w_walk_cmd.pos_a = i_item.first_position;
        w_walk_cmd.pos_b = i_item.second_position;
        w_walk_cmd.ch    = i_item.character;
        unique case (r_state)
            klcp_pkg::ST_CLEAR: begin
                w_rec_we    = 1'b1;
                w_rec_waddr = r_clr;
            end
            klcp_pkg::ST_IDLE: begin
                w_rec_raddr0 = AW'(i_item.first_position);
                w_rec_waddr  = AW'(i_item.first_position);
                if (w_accept && (i_item.op == klcp_pkg::OP_LOAD) && w_in_ok) begin
                    w_rec_we        = 1'b1;
                    w_walk_cmd.load = 1'b1;
                end
                w_walk_cmd.start = w_accept && (i_item.op == klcp_pkg::OP_COMPARE);
            end
            klcp_pkg::ST_CMP_A: begin
                w_rec_we    = w_upd_a;
                w_rec_wdata = '{len: r_res_len, partner: r_b};
            end
            klcp_pkg::ST_CMP_B: begin
                w_rec_we    = r_upd_b;
                w_rec_waddr = AW'(r_b);
                w_rec_wdata = '{len: r_res_len, partner: r_a};
            end
            klcp_pkg::ST_FIN: w_out_load = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    klcp_walk #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_walk_cmd),
        .i_end   (w_end),
        .i_limit (r_limit),
        .o_sts   (w_walk_sts)
    );

    klcp_ram #(
        .WIDTH ($bits(klcp_pkg::t_rec)),
        .DEPTH (TEXT_DEPTH)
    ) u_rec (
        .i_clk    (i_clk),
        .i_we     (w_rec_we),
        .i_waddr  (w_rec_waddr),
        .i_wdata  (w_rec_wdata),
        .i_raddr0 (w_rec_raddr0),
        .i_raddr1 (AW'(r_b)),
        .o_rdata0 (w_rec0),
        .o_rdata1 (w_rec1)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= klcp_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == klcp_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and result capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a       <= i_item.first_position;
            r_b       <= i_item.second_position;
            r_a_ok    <= w_in_ok;
            r_b_ok    <= ({9'b0, i_item.second_position} < DEPTH_W);
            r_res_len <= '0;
            r_res_rec <= '0;
        end
        if ((r_state == klcp_pkg::ST_WALK) && w_walk_sts.done) begin
            r_res_len <= w_walk_sts.match;
        end
        if (r_state == klcp_pkg::ST_READ) begin
            r_res_rec <= w_rec0;
        end
        if (r_state == klcp_pkg::ST_CMP_A) begin
            r_upd_b <= w_upd_b;
        end
        if (w_out_load) begin
            r_out_len <= r_res_len;
            r_out_rec <= r_res_rec;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.match_length = r_out_len;
    assign o_result.best_length  = r_out_rec.len;
    assign o_result.best_partner = r_out_rec.partner;

    // the walker finishes only while the controller waits for it
    a_walk_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk_sts.done |-> (r_state == klcp_pkg::ST_WALK))
        else $error("walk finished outside the walk state");

    // a match never runs past the effective text end
    a_match_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk_sts.done |-> (w_walk_sts.match <= w_end))
        else $error("match length beyond text end");

    // records stay untouched while a walk is in progress
    a_no_rec_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == klcp_pkg::ST_WALK) |-> !w_rec_we)
        else $error("record write during walk");

    // a new result appears only out of the finishing state
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && (r_state == klcp_pkg::ST_IDLE)))
        else $error("result load without return to idle");

endmodule
`default_nettype wire
